FILE: rtl/tpcc_pkg.sv
// Shared types, codes and constants of the tilt pointer and click controller.
`default_nettype none

package tpcc_pkg;

	localparam int TILT_FRAC_BITS_DEF = 12;
	localparam int QUEUE_DEPTH_DEF    = 2;
	localparam int CFG_INDEX_W        = 3;

	localparam logic [14:0] DEAD_ZONE_RST  = 15'd819;
	localparam logic [15:0] CLICK_MIN_RST  = 16'd20;
	localparam logic [15:0] LONG_CLICK_RST = 16'd500;
	localparam logic [31:0] IDLE_SLEEP_RST = 32'd30000;

	localparam logic [4:0] BTN_LEFT  = 5'd1;
	localparam logic [4:0] BTN_RIGHT = 5'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_DEAD_ZONE  = 3'd0,
		CFG_CLICK_MIN  = 3'd1,
		CFG_LONG_CLICK = 3'd2,
		CFG_IDLE_SLEEP = 3'd3,
		CFG_INVERT     = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CLICK_NONE  = 2'd0,
		CLICK_LEFT  = 2'd1,
		CLICK_RIGHT = 2'd2
	} click_t;

	typedef enum logic [1:0] {
		PH_MOTION  = 2'd0,
		PH_PRESS   = 2'd1,
		PH_RELEASE = 2'd2
	} phase_t;

	typedef struct packed {
		logic signed [15:0] tilt_x;
		logic signed [15:0] tilt_y;
		logic               button_down;
		logic [31:0]        now_ms;
		logic               link_up;
	} sample_t;

	typedef struct packed {
		logic              send_report;
		logic [4:0]        button_bits;
		logic signed [7:0] step_x;
		logic signed [7:0] step_y;
		logic [24:0]       led_mask;
		logic              sleep_now;
		logic              last_result;
	} result_t;

	typedef struct packed {
		logic [14:0] dead_zone;
		logic [15:0] click_min_ms;
		logic [15:0] long_click_ms;
		logic [31:0] idle_sleep_ms;
		logic        invert_mode;
	} cfg_t;

	// classified sample, as handed from front to back
	typedef struct packed {
		logic              link_up;
		logic              moved;
		logic signed [7:0] step_x;
		logic signed [7:0] step_y;
		logic [24:0]       arrow_led;
		click_t            click;
		logic [24:0]       click_led;
		logic              sleep_now;
	} cmd_t;

endpackage

`default_nettype wire

FILE: rtl/tpcc_front.sv
// Front end: takes samples, computes steps and clicks, keeps press and activity state.
`default_nettype none

module tpcc_front
	import tpcc_pkg::*;
#(
	parameter int TILT_FRAC_BITS = TILT_FRAC_BITS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cfg_t    cfg,
	input  wire logic    sample_valid,
	output logic         sample_stall,
	input  wire sample_t sample_item,
	output logic         push,
	output cmd_t         push_data,
	input  wire logic    full
);

	logic [31:0]       last_activity_q;
	logic [31:0]       press_start_q;
	logic              press_active_q;

	logic signed [7:0] x, y;
	logic              moved;
	logic              release_now;
	logic [31:0]       held;
	click_t            click;
	logic [31:0]       last_act_new;
	logic [31:0]       idle;
	logic              accept;

	function automatic logic signed [7:0] tilt_step(input logic signed [15:0] v,
		input logic [14:0] dz);
		logic signed [16:0] vs;
		logic signed [16:0] dzs;
		logic signed [16:0] mag_s;
		logic               pos;
		logic               neg;
		logic [19:0]        prod;
		logic [19:0]        q;
		logic [7:0]         m8;
		vs    = {v[15], v};
		dzs   = {2'b00, dz};
		pos   = vs > dzs;
		neg   = vs < -dzs;
		mag_s = pos ? (vs - dzs) : (-vs - dzs);
		prod  = {4'b0000, mag_s[15:0]} * 20'd10;
		q     = prod >> TILT_FRAC_BITS;
		m8    = (q >= 20'd127) ? 8'd127 : (q[7:0] + 8'd1);
		if (pos) begin
			return m8;
		end else if (neg) begin
			return -m8;
		end
		return 8'sd0;
	endfunction

	function automatic logic [24:0] px(input int i);
		return 25'd1 << i;
	endfunction

	function automatic logic [24:0] arrow_mask(input logic signed [7:0] h,
		input logic signed [7:0] v);
		logic [24:0] m;
		m = px(12);
		if (h < 0) begin
			if (v < 0) m |= px(0) | px(6);
			else if (v > 0) m |= px(16) | px(20);
			else m |= px(10) | px(11);
		end else if (h > 0) begin
			if (v < 0) m |= px(8) | px(4);
			else if (v > 0) m |= px(18) | px(24);
			else m |= px(13) | px(14);
		end else begin
			if (v < 0) m |= px(2) | px(7);
			else if (v > 0) m |= px(17) | px(22);
		end
		return m;
	endfunction

	function automatic logic [24:0] click_mask(input logic left_side);
		logic [24:0] m;
		m = px(2) | px(7) | px(12) | px(17) | px(22);
		if (left_side) m |= px(5) | px(10) | px(15) | px(1) | px(21);
		else m |= px(9) | px(14) | px(19) | px(3) | px(23);
		return m;
	endfunction

	always_comb begin
		x           = tilt_step(sample_item.tilt_x, cfg.dead_zone);
		y           = tilt_step(sample_item.tilt_y, cfg.dead_zone);
		moved       = (x != 8'sd0) || (y != 8'sd0);
		release_now = !sample_item.button_down && press_active_q;
		held        = sample_item.now_ms - press_start_q;
		click       = CLICK_NONE;
		if (release_now) begin
			if (held >= {16'd0, cfg.long_click_ms}) click = CLICK_RIGHT;
			else if (held >= {16'd0, cfg.click_min_ms}) click = CLICK_LEFT;
		end
		if (moved || sample_item.button_down || release_now) begin
			last_act_new = sample_item.now_ms;
		end else begin
			last_act_new = last_activity_q;
		end
		idle = sample_item.now_ms - last_act_new;

		push_data.link_up   = sample_item.link_up;
		push_data.moved     = moved;
		push_data.step_x    = cfg.invert_mode ? -x : x;
		push_data.step_y    = cfg.invert_mode ? -y : y;
		push_data.arrow_led = arrow_mask(x, y);
		push_data.click     = click;
		push_data.click_led = click_mask(cfg.invert_mode ^ (click == CLICK_LEFT));
		push_data.sleep_now = idle >= cfg.idle_sleep_ms;
	end

	assign sample_stall = full;
	assign accept       = sample_valid && !full;
	assign push         = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_activity_q <= '0;
			press_start_q   <= '0;
			press_active_q  <= 1'b0;
		end else if (accept) begin
			last_activity_q <= last_act_new;
			if (sample_item.button_down) begin
				if (!press_active_q) begin
					press_active_q <= 1'b1;
					press_start_q  <= sample_item.now_ms;
				end
			end else if (press_active_q) begin
				press_active_q <= 1'b0;
				press_start_q  <= '0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tpcc_fifo.sv
// Short queue of classified samples between front and back.
`default_nettype none

module tpcc_fifo
	import tpcc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_data,
	output logic      full,
	input  wire logic pop,
	output cmd_t      head,
	output logic      head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop) rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tpcc_back.sv
// Back end: expands a classified sample into its results behind an output register.
`default_nettype none

module tpcc_back
	import tpcc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t head,
	input  wire logic head_valid,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result_item
);

	phase_t  phase_q;
	phase_t  phase_d;
	logic    out_valid_q;
	result_t out_q;
	result_t res;
	logic    load;

	assign load = head_valid && (!out_valid_q || !result_stall);

	always_comb begin
		res     = '0;
		phase_d = phase_q;
		case (phase_q)
			PH_MOTION: begin
				res.send_report = head.moved && head.link_up;
				res.step_x      = head.step_x;
				res.step_y      = head.step_y;
				res.led_mask    = head.arrow_led;
				res.last_result = head.click == CLICK_NONE;
			end
			PH_PRESS: begin
				res.send_report = head.link_up;
				res.button_bits = (head.click == CLICK_RIGHT) ? BTN_RIGHT : BTN_LEFT;
				res.led_mask    = head.click_led;
			end
			PH_RELEASE: begin
				res.send_report = head.link_up;
				res.led_mask    = head.click_led;
				res.last_result = 1'b1;
			end
			default: begin
				res.last_result = 1'b1;
			end
		endcase
		res.sleep_now = res.last_result && head.sleep_now;
		pop           = load && res.last_result;
		if (load) begin
			if (res.last_result) begin
				phase_d = PH_MOTION;
			end else if (phase_q == PH_MOTION) begin
				phase_d = PH_PRESS;
			end else begin
				phase_d = PH_RELEASE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MOTION;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (load) out_valid_q <= 1'b1;
			else if (!result_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= res;
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

endmodule

`default_nettype wire

FILE: rtl/tilt_pointer_click_controller_core.sv
// Top level of the tilt pointer and click controller.
// Usage:
//  - sample channel (sample_valid / sample_stall / sample_item) takes one sensor
//    sample per cycle while the internal queue has room.
//  - result channel (result_valid / result_stall / result_item) gives one motion
//    result per sample, followed by a press and a release result when a button
//    release completes a click; last_result marks the final one of a sample.
//  - cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes registers
//    0..4 (dead zone, click min, long click, idle sleep, invert); other indexes
//    are dropped. cfg_ready is always high. Write only while the block is idle.
// Path: an accepted sample is written into the queue, then loaded into the output register.
// Throughput: one sample per cycle while result_stall is low; a click sample holds the
//    result register for its three results in turn, through the single output register.
// Reset: registers return to their defaults, press and activity state clear,
//    queue and output empty.
// When result_stall is high the result holds; the queue absorbs up to
//    QUEUE_DEPTH samples before sample_stall rises.
`default_nettype none

module tilt_pointer_click_controller_core
	import tpcc_pkg::*;
#(
	parameter int TILT_FRAC_BITS = TILT_FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire sample_t                sample_item,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output result_t                     result_item,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]            cfg_data
);

	cfg_t cfg_q;
	logic push;
	cmd_t push_data;
	logic full;
	logic pop;
	cmd_t head;
	logic head_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone     <= DEAD_ZONE_RST;
			cfg_q.click_min_ms  <= CLICK_MIN_RST;
			cfg_q.long_click_ms <= LONG_CLICK_RST;
			cfg_q.idle_sleep_ms <= IDLE_SLEEP_RST;
			cfg_q.invert_mode   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DEAD_ZONE:  cfg_q.dead_zone     <= cfg_data[14:0];
				CFG_CLICK_MIN:  cfg_q.click_min_ms  <= cfg_data[15:0];
				CFG_LONG_CLICK: cfg_q.long_click_ms <= cfg_data[15:0];
				CFG_IDLE_SLEEP: cfg_q.idle_sleep_ms <= cfg_data;
				CFG_INVERT:     cfg_q.invert_mode   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tpcc_front #(
		.TILT_FRAC_BITS(TILT_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item (sample_item),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	tpcc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	tpcc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item)
	);

	// a taken non-final result is followed at once by the next one of its sample
	a_click_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result_item.last_result |=> result_valid)
		else $error("click results not back to back");

	// a press result is followed by the final zero-button release result
	a_press_then_release: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && (result_item.button_bits != 5'd0)
		|=> result_valid && (result_item.button_bits == 5'd0) && result_item.last_result)
		else $error("press result not followed by release");

	// an accepted sample that finds the output empty passes the queue and reaches the output register
	a_sample_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && !result_valid |=> ##1 result_valid)
		else $error("accepted sample did not reach the output");

	// queue holds work only while the output side is busy or about to load
	a_queue_drains: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |=> result_valid)
		else $error("queued item not presented");

endmodule

`default_nettype wire

FILE: tb/tpcc_result_checker.sv
// Result checker for the tilt pointer and click controller: predicts and compares results.
`timescale 1ns / 1ps

module tpcc_result_checker
	import tpcc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_stall,
	input  sample_t                sample_item,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  result_t                result_item,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data,
	output int                     fail_count,
	output int                     outstanding
);

	logic [14:0] zone_cfg;
	logic [15:0] click_min_cfg;
	logic [15:0] long_click_cfg;
	logic [31:0] idle_cfg;
	logic        invert_cfg;

	logic [31:0] last_active_ms;
	logic [31:0] press_began_ms;
	logic        press_held;

	result_t expected_reports[$];
	result_t oldest;

	function automatic logic [24:0] px(int i);
		return 25'd1 << i;
	endfunction

	function automatic int tilt_to_step(logic signed [15:0] raw, logic [14:0] zone);
		int v;
		int dz;
		int mag;
		int q;
		v = raw;
		dz = int'(zone);
		if (v > dz) begin
			mag = v - dz;
		end else if (v < -dz) begin
			mag = -v - dz;
		end else begin
			return 0;
		end
		q = ((mag * 10) >>> TILT_FRAC_BITS_DEF) + 1;
		if (q > 127) begin
			q = 127;
		end
		return (v < 0) ? -q : q;
	endfunction

	function automatic logic [24:0] arrow_led(int h, int v);
		logic [24:0] m;
		m = px(12);
		if (h < 0) begin
			if (v < 0) m |= px(0) | px(6);
			else if (v > 0) m |= px(16) | px(20);
			else m |= px(10) | px(11);
		end else if (h > 0) begin
			if (v < 0) m |= px(8) | px(4);
			else if (v > 0) m |= px(18) | px(24);
			else m |= px(13) | px(14);
		end else begin
			if (v < 0) m |= px(2) | px(7);
			else if (v > 0) m |= px(17) | px(22);
		end
		return m;
	endfunction

	// invert mirrors the picture, not the button
	function automatic logic [24:0] click_led(logic left);
		logic [24:0] m;
		m = px(2) | px(7) | px(12) | px(17) | px(22);
		if (left ^ invert_cfg) begin
			m |= px(5) | px(10) | px(15) | px(1) | px(21);
		end else begin
			m |= px(9) | px(14) | px(19) | px(3) | px(23);
		end
		return m;
	endfunction

	task automatic derive_reports(input sample_t s);
		int sx;
		int sy;
		logic moved;
		click_t click;
		logic [31:0] held;
		logic [31:0] idle_for;
		logic [24:0] led;
		result_t r;
		sx = tilt_to_step(s.tilt_x, zone_cfg);
		sy = tilt_to_step(s.tilt_y, zone_cfg);
		moved = (sx != 0) || (sy != 0);
		r = '0;
		r.send_report = moved && s.link_up;
		r.step_x = 8'(invert_cfg ? -sx : sx);
		r.step_y = 8'(invert_cfg ? -sy : sy);
		r.led_mask = arrow_led(sx, sy);
		if (moved) begin
			last_active_ms = s.now_ms;
		end
		click = CLICK_NONE;
		if (s.button_down) begin
			if (!press_held) begin
				press_held = 1'b1;
				press_began_ms = s.now_ms;
			end
			last_active_ms = s.now_ms;
		end else if (press_held) begin
			held = s.now_ms - press_began_ms;
			if (held >= 32'(long_click_cfg)) click = CLICK_RIGHT;
			else if (held >= 32'(click_min_cfg)) click = CLICK_LEFT;
			press_held = 1'b0;
			press_began_ms = '0;
			last_active_ms = s.now_ms;
		end
		idle_for = s.now_ms - last_active_ms;
		if (click != CLICK_NONE) begin
			expected_reports.push_back(r);
			led = click_led(click == CLICK_LEFT);
			r = '0;
			r.send_report = s.link_up;
			r.button_bits = (click == CLICK_RIGHT) ? BTN_RIGHT : BTN_LEFT;
			r.led_mask = led;
			expected_reports.push_back(r);
			r.button_bits = '0;
		end
		r.sleep_now = idle_for >= idle_cfg;
		r.last_result = 1'b1;
		expected_reports.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_cfg = DEAD_ZONE_RST;
			click_min_cfg = CLICK_MIN_RST;
			long_click_cfg = LONG_CLICK_RST;
			idle_cfg = IDLE_SLEEP_RST;
			invert_cfg = 1'b0;
			last_active_ms = '0;
			press_began_ms = '0;
			press_held = 1'b0;
			expected_reports.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEAD_ZONE:  zone_cfg = cfg_data[14:0];
					CFG_CLICK_MIN:  click_min_cfg = cfg_data[15:0];
					CFG_LONG_CLICK: long_click_cfg = cfg_data[15:0];
					CFG_IDLE_SLEEP: idle_cfg = cfg_data;
					CFG_INVERT:     invert_cfg = cfg_data[0];
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall) begin
				derive_reports(sample_item);
			end
			if (result_valid && !result_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected result %0h", $time, result_item);
					fail_count++;
				end else begin
					oldest = expected_reports.pop_front();
					check_field("send_report", 32'(oldest.send_report),
						32'(result_item.send_report));
					check_field("button_bits", 32'(oldest.button_bits),
						32'(result_item.button_bits));
					check_field("step_x", 32'(oldest.step_x), 32'(result_item.step_x));
					check_field("step_y", 32'(oldest.step_y), 32'(result_item.step_y));
					check_field("led_mask", 32'(oldest.led_mask), 32'(result_item.led_mask));
					check_field("sleep_now", 32'(oldest.sleep_now),
						32'(result_item.sleep_now));
					check_field("last_result", 32'(oldest.last_result),
						32'(result_item.last_result));
				end
			end
		end
		outstanding = expected_reports.size();
	end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the tilt pointer and click controller: stimulus, reset and verdict.
`timescale 1ns / 1ps

module tb_top;
	import tpcc_pkg::*;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   sample_valid;
	logic                   sample_stall;
	sample_t                sample_item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result_item;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [31:0]            cfg_data;
	int                     fail_count;
	int                     outstanding;

	bit          send_burst = 1'b0;
	int          cur_dz = 819;
	logic [31:0] clock_ms = '0;
	logic        hold_level = 1'b0;

	tilt_pointer_click_controller_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item (sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	tpcc_result_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_item (sample_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item (result_item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// result side: random stall before each item, with stall-free stretches
	initial begin
		int  w;
		bit  burst;
		burst = 1'b0;
		result_stall <= 1'b0;
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) burst = !burst;
			w = burst ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				result_stall <= 1'b1;
				repeat (w) @(negedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	task automatic send_sample(input logic signed [15:0] tx, input logic signed [15:0] ty,
			input logic btn, input logic [31:0] stamp, input logic link);
		sample_t s;
		int gap;
		s.tilt_x = tx;
		s.tilt_y = ty;
		s.button_down = btn;
		s.now_ms = stamp;
		s.link_up = link;
		if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
		gap = send_burst ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_item <= s;
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
	endtask

	task automatic press_release(input logic [31:0] down_at, input logic [31:0] up_at,
			input logic link);
		send_sample('0, '0, 1'b1, down_at, link);
		send_sample('0, '0, 1'b0, up_at, link);
	endtask

	// drain everything before touching registers
	task automatic settle();
		sample_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic apply_settings(input int dz, input int cmin, input int lclick,
			input logic [31:0] idle, input logic inv);
		settle();
		write_reg(CFG_DEAD_ZONE, 32'(dz));
		write_reg(CFG_CLICK_MIN, 32'(cmin));
		write_reg(CFG_LONG_CLICK, 32'(lclick));
		write_reg(CFG_IDLE_SLEEP, idle);
		write_reg(CFG_INVERT, 32'(inv));
		cur_dz = dz;
	endtask

	function automatic logic signed [15:0] pick_tilt();
		int v;
		case ($urandom_range(0, 4))
			0: v = 0;
			1: v = int'($urandom_range(0, 2 * cur_dz)) - cur_dz;
			2: begin
				v = cur_dz + int'($urandom_range(1, 2000));
				if (v > 32767) v = 32767;
				if ($urandom_range(0, 1) == 1) v = -v;
			end
			default: v = int'($urandom() & 32'h0000_FFFF);
		endcase
		return 16'(v);
	endfunction

	task automatic run_random(input int count);
		int dt;
		logic link;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		repeat (count) begin
			if ($urandom_range(0, 24) == 0) begin
				clock_ms = $urandom();
			end else begin
				dt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) :
					$urandom_range(0, 200);
				clock_ms += 32'(dt);
			end
			if ($urandom_range(0, 2) == 0) hold_level = !hold_level;
			link = ($urandom_range(0, 7) != 0);
			tx = pick_tilt();
			ty = pick_tilt();
			send_sample(tx, ty, hold_level, clock_ms, link);
		end
	endtask

	initial begin
		int idx;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample_item <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_DEAD_ZONE;
		cfg_data <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: extremes, zone edges, all arrows, link down
		send_sample(16'h7FFF, 16'h8000, 1'b0, 32'd100, 1'b1);
		send_sample(16'h8000, 16'h7FFF, 1'b0, 32'd105, 1'b1);
		send_sample(16'(819), 16'(-819), 1'b0, 32'd110, 1'b1);
		send_sample(16'(820), 16'(-820), 1'b0, 32'd115, 1'b1);
		for (int h = -1; h <= 1; h++) begin
			for (int v = -1; v <= 1; v++) begin
				send_sample(16'(h * 4000), 16'(v * 4000), 1'b0, 32'(200 + h + v), 1'b1);
			end
		end
		send_sample(16'(5000), '0, 1'b0, 32'd300, 1'b0);
		// short hold, left, right with link down, right across the time wrap
		press_release(32'd1000, 32'd1010, 1'b1);
		press_release(32'd2000, 32'd2100, 1'b1);
		press_release(32'd3000, 32'd3600, 1'b0);
		press_release(32'hFFFF_FF00, 32'h0000_0100, 1'b1);
		// one short of the idle limit, then exactly on it
		send_sample('0, '0, 1'b0, 32'h100 + 32'd29999, 1'b1);
		send_sample('0, '0, 1'b0, 32'h100 + 32'd30000, 1'b1);

		apply_settings(32767, 65535, 65535, 32'hFFFF_FFFF, 1'b1);
		send_sample(16'h8000, 16'h7FFF, 1'b0, 32'd40000, 1'b1);
		press_release(32'd50000, 32'd50000 + 32'd65535, 1'b1);
		press_release(32'd200000, 32'd200000 + 32'd65534, 1'b1);

		// right limit below left limit
		apply_settings(0, 1000, 200, 32'd0, 1'b1);
		send_sample(16'sd1, 16'hFFFF, 1'b0, 32'd300000, 1'b1);
		press_release(32'd301000, 32'd301300, 1'b1);
		press_release(32'd302000, 32'd302100, 1'b1);

		apply_settings(100, 0, 65535, 32'd5, 1'b1);
		press_release(32'd400000, 32'd400000, 1'b1);
		settle();
		for (idx = int'(CFG_INVERT) + 1; idx < (1 << CFG_INDEX_W); idx++) begin
			write_reg(CFG_INDEX_W'(idx), $urandom());
		end
		send_sample(16'(5000), 16'(-150), 1'b0, 32'd400010, 1'b0);
		press_release(32'd400020, 32'd400021, 1'b1);

		apply_settings(0, 0, 0, 32'd0, 1'b0);
		press_release(32'd500000, 32'd500000, 1'b1);
		send_sample('0, '0, 1'b0, 32'd500001, 1'b1);

		clock_ms = 32'd600000;
		repeat (4) begin
			apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) :
				$urandom_range(0, 3000), $urandom_range(0, 300), $urandom_range(0, 900),
				($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 2000)) : $urandom(),
				1'($urandom_range(0, 1)));
			run_random(15);
		end

		sample_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/tpcc_pkg.sv
rtl/tpcc_front.sv
rtl/tpcc_fifo.sv
rtl/tpcc_back.sv
rtl/tilt_pointer_click_controller_core.sv
tb/tpcc_result_checker.sv
tb/tb_top.sv
